[hdl/fcpu_pkg.sv]
// shared types, constants and rounding helpers for the fly camera pose update block
`default_nettype none
package fcpu_pkg;

    typedef enum logic [1:0] {
        OP_MOVE   = 2'd0,
        OP_SPEED  = 2'd1,
        OP_MOUSE  = 2'd2,
        OP_SCROLL = 2'd3
    } t_opcode;

    localparam logic [2:0] DIR_FWD   = 3'd0;
    localparam logic [2:0] DIR_BACK  = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_RIGHT = 3'd3;
    localparam logic [2:0] DIR_UP    = 3'd4;
    localparam logic [2:0] DIR_DOWN  = 3'd5;

    localparam logic [1:0] CFG_SENS  = 2'd0;
    localparam logic [1:0] CFG_WUP_X = 2'd1;
    localparam logic [1:0] CFG_WUP_Y = 2'd2;
    localparam logic [1:0] CFG_WUP_Z = 2'd3;

    // angles in q16.16 degrees
    localparam logic signed [31:0] DEG89     = 32'sd5832704;
    localparam logic signed [31:0] DEG90     = 32'sd5898240;
    localparam logic signed [31:0] DEG180    = 32'sd11796480;
    localparam logic signed [31:0] YAW_RESET = -32'sd5898240;
    localparam logic [34:0]        DEG360    = 35'd23592960;
    // 256 turns, keeps the wrap operand positive
    localparam logic signed [35:0] WRAP_BIAS = 36'sd6039797760;

    localparam logic signed [32:0] CORDIC_K = 33'sd652032874;

    localparam logic [13:0] SPEED_RESET = 14'd1280;
    localparam logic [13:0] SPEED_STEP  = 14'd26;
    localparam logic [13:0] SPEED_MAX   = 14'd8960;
    localparam logic [13:0] SPEED_MIN   = 14'd128;
    localparam logic [13:0] ZOOM_MIN    = 14'd256;
    localparam logic [13:0] ZOOM_MAX    = 14'd11520;
    localparam logic signed [15:0] UNIT = 16'sd16384;

    // arctangent of 2^-i in q16.16 degrees
    function automatic logic signed [31:0] atan_deg(input logic [4:0] i);
        logic signed [31:0] r;
        unique case (i)
            5'd0:  r = 32'sd2949120;
            5'd1:  r = 32'sd1740967;
            5'd2:  r = 32'sd919879;
            5'd3:  r = 32'sd466945;
            5'd4:  r = 32'sd234379;
            5'd5:  r = 32'sd117305;
            5'd6:  r = 32'sd58666;
            5'd7:  r = 32'sd29335;
            5'd8:  r = 32'sd14668;
            5'd9:  r = 32'sd7334;
            5'd10: r = 32'sd3667;
            5'd11: r = 32'sd1833;
            5'd12: r = 32'sd917;
            5'd13: r = 32'sd458;
            5'd14: r = 32'sd229;
            5'd15: r = 32'sd115;
            5'd16: r = 32'sd57;
            5'd17: r = 32'sd29;
            5'd18: r = 32'sd14;
            5'd19: r = 32'sd7;
            5'd20: r = 32'sd4;
            5'd21: r = 32'sd2;
            5'd22: r = 32'sd1;
            default: r = 32'sd0;
        endcase
        return r;
    endfunction

    // shift right, rounding half away from zero
    function automatic logic signed [65:0] rnd_shift(input logic signed [65:0] v,
                                                     input int unsigned s);
        logic [65:0] mag;
        mag = v[65] ? 66'(-v) : 66'(v);
        mag = (mag + (66'd1 << (s - 1))) >> s;
        return v[65] ? -$signed(mag) : $signed(mag);
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [31:0] r;
        if (v > $signed(35'h0_7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < $signed(35'h7_8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

[hdl/fly_camera_pose_update_top.sv]
// fly camera pose update: event sequencer around one shared multiplier
// mouse items are dominated by three normalisations, each a 32-step square root and
//   three 15-step restoring divisions
// throughput: one item at a time; s_axis_tready is high only while the sequencer is idle
// reset: i_rst_n synchronous active low, restores the initial pose and register values
`default_nettype none
module fly_camera_pose_update_top #(
    parameter int CORDIC_STEPS = 16          // cordic rotations per sine/cosine, 8..24
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // input items
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // move_dir[2:0] faster[3] delta_time[19:4] x_offset[43:20] y_offset[67:44]
    // clamp_pitch[68], zero pad above
    input  wire logic [71:0]  s_axis_tdata,
    // opcode[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    // result items
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // pos_x[31:0] pos_y[63:32] pos_z[95:64] front_x[111:96] front_y[127:112]
    // front_z[143:128] up_x[159:144] up_y[175:160] up_z[191:176]
    // zoom_level[205:192] speed_now[219:206], zero pad above
    output logic [223:0]      m_axis_tdata,
    // configuration writes
    input  wire logic         i_cfg_we,
    input  wire logic [1:0]   i_cfg_addr,
    input  wire logic [15:0]  i_cfg_data
);

    typedef enum logic [21:0] {
        S_IDLE  = 22'h000001,
        S_MISC  = 22'h000002,
        S_MVEL  = 22'h000004,
        S_MMUL  = 22'h000008,
        S_MADD  = 22'h000010,
        S_MDX   = 22'h000020,
        S_MYAW  = 22'h000040,
        S_WRAP  = 22'h000080,
        S_MPIT  = 22'h000100,
        S_CINIT = 22'h000200,
        S_CROT  = 22'h000400,
        S_CEND  = 22'h000800,
        S_F0    = 22'h001000,
        S_F1    = 22'h002000,
        S_F2    = 22'h004000,
        S_NSQ   = 22'h008000,
        S_NSQRT = 22'h010000,
        S_NDINI = 22'h020000,
        S_NDIV  = 22'h040000,
        S_NDOUT = 22'h080000,
        S_XPR   = 22'h100000,
        S_DONE  = 22'h200000
    } t_state;

    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);

    t_state r_state;

    // architectural pose
    logic signed [31:0] r_pos   [3];
    logic signed [31:0] r_yaw;
    logic signed [31:0] r_pitch;
    logic        [13:0] r_speed;
    logic        [13:0] r_zoom;
    logic signed [15:0] r_front [3];
    logic signed [15:0] r_right [3];
    logic signed [15:0] r_up    [3];
    // configuration
    logic        [15:0] r_sens;
    logic signed [15:0] r_wup   [3];
    // latched item
    fcpu_pkg::t_opcode  r_op;
    logic        [2:0]  r_dir;
    logic               r_faster;
    logic        [15:0] r_dt;
    logic signed [23:0] r_xo;
    logic signed [23:0] r_yo;
    logic               r_clamp;
    // working registers
    logic        [4:0]  r_cnt;
    logic        [1:0]  r_idx;
    logic        [1:0]  r_nsel;       // 0 front, 1 right, 2 up being normalised
    logic               r_run;
    logic        [29:0] r_vel;
    logic signed [65:0] r_prod;
    logic        [34:0] r_wr;
    logic signed [32:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic               r_flip;
    logic signed [32:0] r_sy, r_cy, r_sp, r_cp;
    logic signed [32:0] r_nv    [3];
    logic        [63:0] r_sum, r_res, r_bit;
    logic        [47:0] r_rem;
    logic        [14:0] r_q;
    // output register
    logic               r_ovalid;
    logic        [223:0] r_odata;

    // input field unpacking
    logic        [2:0]  in_dir;
    logic               in_faster;
    logic        [15:0] in_dt;
    logic        [23:0] in_xo, in_yo;
    logic               in_clamp;
    assign in_dir    = s_axis_tdata[2:0];
    assign in_faster = s_axis_tdata[3];
    assign in_dt     = s_axis_tdata[19:4];
    assign in_xo     = s_axis_tdata[43:20];
    assign in_yo     = s_axis_tdata[67:44];
    assign in_clamp  = s_axis_tdata[68];

    logic in_acc, out_load;
    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_load      = (r_state == S_DONE) && (!r_ovalid || m_axis_tready);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // magnitudes of the vector under normalisation
    logic [31:0] nv_mag [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            nv_mag[i] = r_nv[i][32] ? 32'(-r_nv[i]) : r_nv[i][31:0];
        end
    end

    // move direction vector and sign
    logic signed [15:0] mv_comp;
    logic               mv_neg;
    always_comb begin
        priority case (r_dir)
            fcpu_pkg::DIR_LEFT, fcpu_pkg::DIR_RIGHT: mv_comp = r_right[r_idx];
            fcpu_pkg::DIR_UP, fcpu_pkg::DIR_DOWN:    mv_comp = r_up[r_idx];
            default:                                 mv_comp = r_front[r_idx];
        endcase
        mv_neg = (r_dir == fcpu_pkg::DIR_BACK) || (r_dir == fcpu_pkg::DIR_LEFT)
              || (r_dir == fcpu_pkg::DIR_DOWN);
    end

    // cross product term selection: term k of a x b
    logic signed [15:0] xa, xb;
    logic [1:0]         xai, xbi;
    always_comb begin
        unique case (r_cnt[2:0])
            3'd0:    begin xai = 2'd1; xbi = 2'd2; end
            3'd1:    begin xai = 2'd2; xbi = 2'd1; end
            3'd2:    begin xai = 2'd2; xbi = 2'd0; end
            3'd3:    begin xai = 2'd0; xbi = 2'd2; end
            3'd4:    begin xai = 2'd0; xbi = 2'd1; end
            3'd5:    begin xai = 2'd1; xbi = 2'd0; end
            default: begin xai = 2'd0; xbi = 2'd0; end
        endcase
        // right = front x world up, up = right x front
        if (r_nsel == 2'd1) begin
            xa = r_front[xai];
            xb = r_wup[xbi];
        end else begin
            xa = r_right[xai];
            xb = r_front[xbi];
        end
    end

    // the shared multiplier
    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_p;
    logic [1:0]         sq_i;
    always_comb begin
        sq_i = (r_cnt[1:0] == 2'd3) ? 2'd0 : r_cnt[1:0];
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MVEL: begin
                mul_a = {19'd0, r_speed};
                mul_b = {17'd0, r_dt};
            end
            S_MMUL: begin
                mul_a = 33'(mv_comp);
                mul_b = {3'd0, r_vel};
            end
            S_MDX: begin
                mul_a = 33'(r_xo);
                mul_b = {17'd0, r_sens};
            end
            S_MYAW: begin
                mul_a = 33'(r_yo);
                mul_b = {17'd0, r_sens};
            end
            S_F0: begin
                mul_a = r_cy;
                mul_b = r_cp;
            end
            S_F1: begin
                mul_a = r_sy;
                mul_b = r_cp;
            end
            S_NSQ: begin
                mul_a = {1'b0, nv_mag[sq_i]};
                mul_b = {1'b0, nv_mag[sq_i]};
            end
            S_XPR: begin
                mul_a = 33'(xa);
                mul_b = 33'(xb);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // datapath helpers
    logic signed [65:0] rs8, rs22, rs30;
    logic signed [34:0] n_possum;
    logic signed [33:0] mv_d;
    logic signed [34:0] n_yawsum, n_pitsum;
    logic signed [31:0] n_pitch, n_wraps;
    logic signed [35:0] n_wrap_yaw, n_wrap_pit, wr_s;
    logic        [34:0] wr_sub;
    logic signed [31:0] c_ang, c_z;
    logic               c_flip;
    logic signed [32:0] c_xs, c_ys;
    logic signed [31:0] c_at;
    logic        [63:0] sq_t;
    logic        [47:0] dv_sub;
    logic        [14:0] dv_qc;
    logic signed [15:0] dv_out;
    logic signed [25:0] n_zoom;
    logic signed [32:0] x_p, x_km1;
    logic        [4:0]  x_k;

    always_comb begin
        rs8  = fcpu_pkg::rnd_shift(r_prod, 8);
        rs22 = fcpu_pkg::rnd_shift(r_prod, 22);
        rs30 = fcpu_pkg::rnd_shift(r_prod, 30);

        // move step, position add saturates
        mv_d     = mv_neg ? -rs22[33:0] : rs22[33:0];
        n_possum = 35'(r_pos[r_idx]) + 35'(mv_d);

        // yaw and pitch sums
        n_yawsum   = 35'(r_yaw) + 35'($signed(rs8[33:0]));
        n_wrap_yaw = 36'(n_yawsum) + 36'(fcpu_pkg::DEG180) + fcpu_pkg::WRAP_BIAS;
        n_pitsum   = 35'(r_pitch) + 35'($signed(rs8[33:0]));
        n_pitch    = fcpu_pkg::sat32(n_pitsum);
        if (r_clamp) begin
            if (n_pitch > fcpu_pkg::DEG89) begin
                n_pitch = fcpu_pkg::DEG89;
            end
            if (n_pitch < -fcpu_pkg::DEG89) begin
                n_pitch = -fcpu_pkg::DEG89;
            end
        end
        n_wrap_pit = 36'(n_pitch) + 36'(fcpu_pkg::DEG180) + fcpu_pkg::WRAP_BIAS;

        // modulo by one turn, one shifted turn per step
        wr_sub  = fcpu_pkg::DEG360 << r_cnt[3:0];
        wr_s    = $signed({1'b0, r_wr}) - 36'(fcpu_pkg::DEG180);
        n_wraps = wr_s[31:0];

        // cordic fold into plus or minus 90 degrees
        c_ang  = r_run ? n_wraps : r_yaw;
        c_flip = 1'b1;
        if (c_ang > fcpu_pkg::DEG90) begin
            c_z = fcpu_pkg::DEG180 - c_ang;
        end else if (c_ang < -fcpu_pkg::DEG90) begin
            c_z = -fcpu_pkg::DEG180 - c_ang;
        end else begin
            c_z    = c_ang;
            c_flip = 1'b0;
        end
        c_xs = r_x >>> r_cnt;
        c_ys = r_y >>> r_cnt;
        c_at = fcpu_pkg::atan_deg(r_cnt);

        // square root and divider add-compare steps
        sq_t   = r_res + r_bit;
        dv_sub = {15'd0, r_res[32:0]} << r_cnt[3:0];
        dv_qc  = (r_q > 15'd16384) ? 15'd16384 : r_q;
        if (r_res == 64'd0) begin
            dv_out = '0;
        end else if (r_nv[r_idx][32]) begin
            dv_out = -$signed({1'b0, dv_qc});
        end else begin
            dv_out = $signed({1'b0, dv_qc});
        end

        // scroll
        n_zoom = $signed({12'd0, r_zoom}) - 26'(r_yo);

        // cross product accumulate
        x_k   = r_cnt - 5'd1;
        x_p   = r_prod[32:0];
        x_km1 = r_nv[x_k[2:1]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= '0;
            end
            r_yaw    <= fcpu_pkg::YAW_RESET;
            r_pitch  <= '0;
            r_speed  <= fcpu_pkg::SPEED_RESET;
            r_zoom   <= fcpu_pkg::ZOOM_MAX;
            r_front[0] <= '0; r_front[1] <= '0; r_front[2] <= -fcpu_pkg::UNIT;
            r_right[0] <= fcpu_pkg::UNIT; r_right[1] <= '0; r_right[2] <= '0;
            r_up[0] <= '0; r_up[1] <= fcpu_pkg::UNIT; r_up[2] <= '0;
            r_sens   <= 16'd6554;
            r_wup[0] <= '0; r_wup[1] <= fcpu_pkg::UNIT; r_wup[2] <= '0;
            r_run    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_addr)
                    fcpu_pkg::CFG_SENS:  r_sens   <= i_cfg_data;
                    fcpu_pkg::CFG_WUP_X: r_wup[0] <= i_cfg_data;
                    fcpu_pkg::CFG_WUP_Y: r_wup[1] <= i_cfg_data;
                    fcpu_pkg::CFG_WUP_Z: r_wup[2] <= i_cfg_data;
                endcase
            end

            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= fcpu_pkg::t_opcode'(s_axis_tuser);
                        r_dir    <= in_dir;
                        r_faster <= in_faster;
                        r_dt     <= in_dt;
                        r_xo     <= in_xo;
                        r_yo     <= in_yo;
                        r_clamp  <= in_clamp;
                        r_idx    <= '0;
                        unique case (fcpu_pkg::t_opcode'(s_axis_tuser))
                            fcpu_pkg::OP_MOVE:  r_state <= S_MVEL;
                            fcpu_pkg::OP_MOUSE: r_state <= S_MDX;
                            default:            r_state <= S_MISC;
                        endcase
                    end
                end
                S_MISC: begin
                    if (r_op == fcpu_pkg::OP_SPEED) begin
                        if (r_faster) begin
                            if (r_speed < fcpu_pkg::SPEED_MAX) begin
                                r_speed <= r_speed + fcpu_pkg::SPEED_STEP;
                            end
                        end else if (r_speed > fcpu_pkg::SPEED_MIN) begin
                            r_speed <= r_speed - fcpu_pkg::SPEED_STEP;
                        end
                    end else begin
                        priority if (n_zoom < $signed({12'd0, fcpu_pkg::ZOOM_MIN})) begin
                            r_zoom <= fcpu_pkg::ZOOM_MIN;
                        end else if (n_zoom > $signed({12'd0, fcpu_pkg::ZOOM_MAX})) begin
                            r_zoom <= fcpu_pkg::ZOOM_MAX;
                        end else begin
                            r_zoom <= n_zoom[13:0];
                        end
                    end
                    r_state <= S_DONE;
                end
                // move: velocity, then each component through a multiply state and an add state
                S_MVEL: begin
                    r_vel <= mul_p[29:0];
                    r_state <= (r_dir > fcpu_pkg::DIR_DOWN) ? S_DONE : S_MMUL;
                end
                S_MMUL: begin
                    r_prod  <= mul_p;
                    r_state <= S_MADD;
                end
                S_MADD: begin
                    r_pos[r_idx] <= fcpu_pkg::sat32(n_possum);
                    if (r_idx == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_MMUL;
                    end
                end
                // mouse: scaled offsets, yaw and pitch wrap
                S_MDX: begin
                    r_prod  <= mul_p;
                    r_state <= S_MYAW;
                end
                S_MYAW: begin
                    r_wr    <= n_wrap_yaw[34:0];
                    r_prod  <= mul_p;
                    r_cnt   <= 5'd8;
                    r_run   <= 1'b0;
                    r_state <= S_WRAP;
                end
                S_WRAP: begin
                    if (r_wr >= wr_sub) begin
                        r_wr <= r_wr - wr_sub;
                    end
                    if (r_cnt == 5'd0) begin
                        if (r_run) begin
                            r_run   <= 1'b0;
                            r_state <= S_CINIT;
                        end else begin
                            r_state <= S_MPIT;
                        end
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_MPIT: begin
                    r_yaw   <= n_wraps;
                    r_pitch <= n_pitch;
                    r_wr    <= n_wrap_pit[34:0];
                    r_cnt   <= 5'd8;
                    r_run   <= 1'b1;
                    r_state <= S_WRAP;
                end
                // sine and cosine, yaw first then wrapped pitch
                S_CINIT: begin
                    r_x     <= fcpu_pkg::CORDIC_K;
                    r_y     <= '0;
                    r_z     <= c_z;
                    r_flip  <= c_flip;
                    r_cnt   <= '0;
                    r_state <= S_CROT;
                end
                S_CROT: begin
                    if (!r_z[31]) begin
                        r_x <= r_x - c_ys;
                        r_y <= r_y + c_xs;
                        r_z <= r_z - c_at;
                    end else begin
                        r_x <= r_x + c_ys;
                        r_y <= r_y - c_xs;
                        r_z <= r_z + c_at;
                    end
                    if (r_cnt == CORDIC_LAST) begin
                        r_state <= S_CEND;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_CEND: begin
                    if (r_run) begin
                        r_sp    <= r_y;
                        r_cp    <= r_flip ? -r_x : r_x;
                        r_run   <= 1'b0;
                        r_state <= S_F0;
                    end else begin
                        r_sy    <= r_y;
                        r_cy    <= r_flip ? -r_x : r_x;
                        r_run   <= 1'b1;
                        r_state <= S_CINIT;
                    end
                end
                // raw front vector
                S_F0: begin
                    r_prod  <= mul_p;
                    r_state <= S_F1;
                end
                S_F1: begin
                    r_nv[0] <= rs30[32:0];
                    r_prod  <= mul_p;
                    r_state <= S_F2;
                end
                S_F2: begin
                    r_nv[2] <= rs30[32:0];
                    r_nv[1] <= r_sp;
                    r_nsel  <= 2'd0;
                    r_cnt   <= '0;
                    r_sum   <= '0;
                    r_state <= S_NSQ;
                end
                // normalise: sum of squares, square root, three divisions
                S_NSQ: begin
                    if (r_cnt != 5'd3) begin
                        r_prod <= mul_p;
                    end
                    if (r_cnt != 5'd0) begin
                        r_sum <= r_sum + r_prod[63:0];
                    end
                    if (r_cnt == 5'd3) begin
                        r_res   <= '0;
                        r_bit   <= 64'h4000_0000_0000_0000;
                        r_state <= S_NSQRT;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_NSQRT: begin
                    if (r_sum >= sq_t) begin
                        r_sum <= r_sum - sq_t;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_idx   <= '0;
                        r_state <= S_NDINI;
                    end
                end
                S_NDINI: begin
                    r_rem   <= {2'd0, nv_mag[r_idx], 14'd0} + {16'd0, r_res[32:1]};
                    r_q     <= '0;
                    r_cnt   <= 5'd14;
                    r_state <= S_NDIV;
                end
                S_NDIV: begin
                    if (r_rem >= dv_sub) begin
                        r_rem <= r_rem - dv_sub;
                        r_q   <= r_q | (15'd1 << r_cnt[3:0]);
                    end
                    if (r_cnt == 5'd0) begin
                        r_state <= S_NDOUT;
                    end else begin
                        r_cnt <= r_cnt - 5'd1;
                    end
                end
                S_NDOUT: begin
                    unique case (r_nsel)
                        2'd0:    r_front[r_idx] <= dv_out;
                        2'd1:    r_right[r_idx] <= dv_out;
                        default: r_up[r_idx]    <= dv_out;
                    endcase
                    if (r_idx != 2'd2) begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_NDINI;
                    end else if (r_nsel == 2'd2) begin
                        r_state <= S_DONE;
                    end else begin
                        r_nsel  <= r_nsel + 2'd1;
                        r_cnt   <= '0;
                        r_state <= S_XPR;
                    end
                end
                // cross product, one term per cycle
                S_XPR: begin
                    if (r_cnt != 5'd6) begin
                        r_prod <= mul_p;
                    end
                    if (r_cnt != 5'd0) begin
                        r_nv[x_k[2:1]] <= x_k[0] ? (x_km1 - x_p) : x_p;
                    end
                    if (r_cnt == 5'd6) begin
                        r_cnt   <= '0;
                        r_sum   <= '0;
                        r_state <= S_NSQ;
                    end else begin
                        r_cnt <= r_cnt + 5'd1;
                    end
                end
                S_DONE: begin
                    if (out_load) begin
                        r_odata <= {4'd0, r_speed, r_zoom,
                                    r_up[2], r_up[1], r_up[0],
                                    r_front[2], r_front[1], r_front[0],
                                    r_pos[2], r_pos[1], r_pos[0]};
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[hdl/fcpu_chk.sv]
// port-level checker for the fly camera pose update block, with its bind
`default_nettype none
module fcpu_chk (
    input wire logic         i_clk,
    input wire logic         i_rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [223:0] m_axis_tdata
);

    // no result straight out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // one item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input taken while an item is in work");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

    // zoom kept within one to 45 degrees
    a_zoom_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[205:192] >= 14'd256
                           && m_axis_tdata[205:192] <= 14'd11520))
        else $error("zoom out of range");

    // front x stays a unit component
    a_front_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ($signed(m_axis_tdata[111:96]) <= 16'sd16384
                           && $signed(m_axis_tdata[111:96]) >= -16'sd16384))
        else $error("front x beyond unit length");

endmodule

bind fly_camera_pose_update_top fcpu_chk u_fcpu_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
